/* src/assert_macros.svh */
// Assertion macros used by the checker module of the slice continuity tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, suspended while rst_n is low.
`define TSCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define TSCT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/tsct_pkg.sv */
// Types and constants shared by the slice continuity tracker modules.
package tsct_pkg;

    localparam int PID_W      = 13;
    localparam int CC_W       = 4;
    localparam int PTS_MS_W   = 27;
    localparam int PEND_W     = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [PID_W-1:0]  PID_RESET  = 13'h1011;
    localparam logic [7:0]        HLEN_SHORT = 8'h05;
    localparam logic [7:0]        HLEN_LONG  = 8'h0A;
    localparam logic [PEND_W-1:0] PEND_MAX   = 16'hFFFF;
    localparam logic [31:0]       RECIP_45   = 32'd3054198966;
    localparam logic [31:0]       DIV_45     = 32'd45;

    localparam logic CFG_IDX_VIDEO_PID = 1'b0;

    typedef enum logic [1:0] {
        VERDICT_DISCARD = 2'd0,
        VERDICT_APPEND  = 2'd1,
        VERDICT_CLOSE   = 2'd2,
        VERDICT_LOSS    = 2'd3
    } verdict_t;

    typedef struct packed {
        logic                start_seen;
        logic [PTS_MS_W-1:0] start_pts;
        logic                video_seen;
        logic [CC_W-1:0]     first_cc;
        logic [CC_W-1:0]     last_cc;
        logic                format_bad;
    } dgram_sum_t;

endpackage

/* src/tsct_front.sv */
// Front part: accepts packet headers, converts the PTS and builds one summary per datagram.
module tsct_front
    import tsct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [71:0]      s_tdata,
    input  logic             s_tuser,
    input  logic             s_tlast,
    input  logic [PID_W-1:0] video_pid,
    input  logic             fifo_full,
    output logic             push,
    output dgram_sum_t       push_sum
);

    logic             s1_valid_reg;
    logic             s1_hit_reg;
    logic             s1_pusi_reg;
    logic [CC_W-1:0]  s1_cc_reg;
    logic             s1_bad_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;
    logic [31:0]      s1_y_reg;
    logic [63:0]      s1_prod_reg;

    dgram_sum_t       acc_reg;
    dgram_sum_t       acc_next;
    dgram_sum_t       upd;

    logic [39:0]          pts_raw;
    logic [31:0]          y_in;
    logic [7:0]           hlen_in;
    logic [PTS_MS_W-1:0]  q_est;
    logic [31:0]          rem;
    logic [PTS_MS_W-1:0]  pts_ms;
    logic                 blocked;
    logic                 fire;

    assign pts_raw  = s_tdata[67:28];
    assign hlen_in  = s_tdata[27:20];
    assign y_in     = {pts_raw[35:33], pts_raw[31:17], pts_raw[15:2]};
    assign blocked  = s1_valid_reg && s1_last_reg && fifo_full;
    assign s_tready = !blocked;
    assign fire     = s1_valid_reg && !blocked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            s1_hit_reg   <= (s_tdata[12:0] == video_pid);
            s1_pusi_reg  <= s_tdata[13];
            s1_cc_reg    <= s_tdata[19:16];
            s1_bad_reg   <= (hlen_in != HLEN_SHORT) && (hlen_in != HLEN_LONG);
            s1_first_reg <= s_tuser;
            s1_last_reg  <= s_tlast;
            s1_y_reg     <= y_in;
            s1_prod_reg  <= {32'd0, y_in} * {32'd0, RECIP_45};
        end
    end

    // The reciprocal estimate is low by at most one; a single compare fixes it.
    always_comb
    begin
        q_est  = s1_prod_reg[63:37];
        rem    = s1_y_reg - ({5'd0, q_est} * DIV_45);
        pts_ms = q_est + PTS_MS_W'(rem >= DIV_45);
    end

    always_comb
    begin
        upd = s1_first_reg ? '0 : acc_reg;
        if (s1_hit_reg)
        begin
            if (!upd.video_seen)
            begin
                upd.video_seen = 1'b1;
                upd.first_cc   = s1_cc_reg;
            end
            upd.last_cc = s1_cc_reg;
            if (s1_pusi_reg && !upd.start_seen)
            begin
                upd.start_seen = 1'b1;
                upd.start_pts  = pts_ms;
                if (s1_bad_reg)
                begin
                    upd.format_bad = 1'b1;
                end
            end
        end
        push     = fire && s1_last_reg;
        push_sum = upd;
        if (push)
        begin
            acc_next = '0;
        end
        else if (fire)
        begin
            acc_next = upd;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

/* src/tsct_fifo.sv */
// Short queue of datagram summaries between the front and back parts.
module tsct_fifo
    import tsct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  dgram_sum_t push_sum,
    input  logic       pop,
    output dgram_sum_t pop_sum,
    output logic       full,
    output logic       empty
);

    dgram_sum_t         mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_sum = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* src/tsct_back.sv */
// Back part: applies each datagram summary to the slice state and holds the verdict beat.
module tsct_back
    import tsct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  dgram_sum_t  pop_sum,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    logic                hunting_reg;
    logic                hunting_next;
    logic [PEND_W-1:0]   pend_reg;
    logic [PEND_W-1:0]   pend_next;
    logic [CC_W-1:0]     exp_cc_reg;
    logic [CC_W-1:0]     exp_cc_next;
    logic [PTS_MS_W-1:0] slice_pts_reg;
    logic [PTS_MS_W-1:0] slice_pts_next;

    verdict_t            verdict;
    logic [PTS_MS_W-1:0] closed_pts;

    logic                out_valid_reg;
    verdict_t            out_verdict_reg;
    logic [PTS_MS_W-1:0] out_pts_reg;
    logic                out_fmt_reg;

    assign pop      = !empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_fmt_reg, out_pts_reg, out_verdict_reg};

    always_comb
    begin
        verdict        = VERDICT_DISCARD;
        closed_pts     = '0;
        hunting_next   = hunting_reg;
        pend_next      = pend_reg;
        exp_cc_next    = exp_cc_reg;
        slice_pts_next = slice_pts_reg;
        if (pop && !(hunting_reg && !pop_sum.start_seen))
        begin
            hunting_next = 1'b0;
            verdict      = VERDICT_APPEND;
            if (pop_sum.start_seen)
            begin
                if (pend_reg != '0)
                begin
                    verdict    = VERDICT_CLOSE;
                    closed_pts = slice_pts_reg;
                    pend_next  = '0;
                end
                slice_pts_next = pop_sum.start_pts;
            end
            if (pop_sum.video_seen)
            begin
                if (pend_next == '0)
                begin
                    exp_cc_next = pop_sum.last_cc;
                end
                else if ((exp_cc_reg + 1'b1) == pop_sum.first_cc)
                begin
                    exp_cc_next = pop_sum.last_cc;
                end
                else
                begin
                    verdict      = VERDICT_LOSS;
                    hunting_next = 1'b1;
                    pend_next    = '0;
                end
            end
            if (verdict != VERDICT_LOSS && pend_next != PEND_MAX)
            begin
                pend_next = pend_next + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg   <= 1'b1;
            pend_reg      <= '0;
            exp_cc_reg    <= '0;
            slice_pts_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hunting_reg   <= hunting_next;
            pend_reg      <= pend_next;
            exp_cc_reg    <= exp_cc_next;
            slice_pts_reg <= slice_pts_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_verdict_reg <= verdict;
            out_pts_reg     <= closed_pts;
            out_fmt_reg     <= pop_sum.format_bad;
        end
    end

endmodule

/* src/ts_slice_continuity_tracker.sv */
// Top level of the transport stream slice continuity tracker.
// The block accepts one transport packet header beat per cycle and returns one verdict beat
// for each beat marked with tlast (datagram end); each verdict is registered in the front's
// header stage, the summary queue and the back's output register. The front registers the
// header and the 32-by-32 reciprocal product that turns the PTS into milliseconds, then folds
// the packet into the datagram summary; a four-entry queue hands the summaries to the back,
// which updates the slice state and holds the verdict in an output register. s_tready falls
// only while a datagram end waits for room in that queue. There is no clearing pass.
module ts_slice_continuity_tracker
    import tsct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Packet header stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // pid[12:0], payload_start[13], adaptation_control[15:14], continuity[19:16],
    // pes_header_len_byte[27:20], pts_bytes[67:28], zero pad [71:68]
    input  logic [71:0] s_tdata,
    // first_in_datagram[0]
    input  logic        s_tuser,
    input  logic        s_tlast,
    // Verdict stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // verdict[1:0], closed_slice_pts_ms[28:2], format_error[29], zero pad [31:30]
    output logic [31:0] m_tdata
);

    logic [PID_W-1:0] video_pid_reg;
    logic             cfg_write;
    logic             fifo_full;
    logic             fifo_empty;
    logic             push;
    logic             pop;
    dgram_sum_t       push_sum;
    dgram_sum_t       pop_sum;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == CFG_IDX_VIDEO_PID);
    assign prdata    = (paddr[2] == CFG_IDX_VIDEO_PID) ? {19'd0, video_pid_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_pid_reg <= PID_RESET;
        end
        else if (cfg_write)
        begin
            video_pid_reg <= pwdata[PID_W-1:0];
        end
    end

    tsct_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .video_pid (video_pid_reg),
        .fifo_full (fifo_full),
        .push      (push),
        .push_sum  (push_sum)
    );

    tsct_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_sum (push_sum),
        .pop      (pop),
        .pop_sum  (pop_sum),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    tsct_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (fifo_empty),
        .pop_sum  (pop_sum),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* src/tsct_checker.sv */
// Port-level checker for the slice continuity tracker and its bind statement.
`include "assert_macros.svh"

module tsct_checker
    import tsct_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic [3:0] open_reg;
    logic [3:0] open_next;
    logic       in_end;
    logic       out_beat;
    logic       out_stall;
    logic       not_close;

    assign in_end    = s_tvalid && s_tready && s_tlast;
    assign out_beat  = m_tvalid && m_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign not_close = m_tvalid && (m_tdata[1:0] != VERDICT_CLOSE);

    always_comb
    begin
        open_next = open_reg + {3'd0, in_end} - {3'd0, out_beat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    `TSCT_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(m_tdata), "stalled beat changed")
    `TSCT_ASSERT(a_pts_only_on_close, not_close |-> (m_tdata[28:2] == '0), "PTS without close")
    `TSCT_ASSERT(a_no_invented, m_tvalid |-> (open_reg != '0), "verdict beat without datagram end")
    `TSCT_ASSERT_ALWAYS(a_open_bound, !rst_n || (open_reg <= 4'd6), "too many ends in flight")

endmodule

bind ts_slice_continuity_tracker tsct_checker u_tsct_checker (.*);
